>>> rtl/exc1d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exc1d_pkg
// Shared types and codes for the type 1 exciter derivative block: register
// map, regulator limit codes, configuration set and beat layouts.
// ----------------------------------------------------------------------------
package exc1d_pkg;

  localparam int RegAddrW = 5;
  localparam int RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] REG_GAIN_AMP      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAIN_EXCITER  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_GAIN_FEEDBACK = 3'd2;
  localparam logic [RegIdxW-1:0] REG_INV_TIME_AMP  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_INV_TIME_EXC  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_INV_TIME_FB   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SAT_OFFSET    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SAT_SCALE     = 3'd7;

  localparam logic [1:0] LIM_FREE = 2'd0;
  localparam logic [1:0] LIM_MAX  = 2'd1;
  localparam logic [1:0] LIM_MIN  = 2'd2;

  typedef struct packed {
    logic signed [31:0] gain_amp;
    logic signed [31:0] gain_exciter;
    logic signed [31:0] gain_feedback;
    logic        [30:0] inv_time_amp;
    logic        [30:0] inv_time_exciter;
    logic        [30:0] inv_time_feedback;
    logic signed [31:0] sat_offset;
    logic        [30:0] sat_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] field_volt;
    logic signed [31:0] sensed_volt;
    logic signed [31:0] reg_out;
    logic signed [31:0] fb_state;
    logic signed [31:0] gen_volt;
    logic signed [31:0] ref_volt;
    logic signed [31:0] oel_signal;
    logic signed [31:0] uel_signal;
    logic               uel_active;
    logic        [1:0]  limit_state;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] d_field_volt;
    logic signed [31:0] d_sensed_volt;
    logic signed [31:0] d_reg_out;
    logic signed [31:0] d_fb_state;
  } out_beat_t;

endpackage

>>> rtl/exc1d_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exc1d_regs
// Configuration register file behind an APB-style port. Eight registers at
// word addresses; writes land on the access phase, reads are combinational.
// ----------------------------------------------------------------------------
module exc1d_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [exc1d_pkg::RegAddrW-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output exc1d_pkg::cfg_t                 cfg
);
  import exc1d_pkg::*;

  cfg_t               cfg_r;
  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[RegAddrW-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_amp          <= 32'sd3276800;
      cfg_r.gain_exciter      <= 32'sd3932;
      cfg_r.gain_feedback     <= 32'sd5898;
      cfg_r.inv_time_amp      <= 31'd1638400;
      cfg_r.inv_time_exciter  <= 31'd1092266;
      cfg_r.inv_time_feedback <= 31'd44887;
      cfg_r.sat_offset        <= 32'sd0;
      cfg_r.sat_scale         <= 31'd0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_AMP:      cfg_r.gain_amp          <= pwdata;
        REG_GAIN_EXCITER:  cfg_r.gain_exciter      <= pwdata;
        REG_GAIN_FEEDBACK: cfg_r.gain_feedback     <= pwdata;
        REG_INV_TIME_AMP:  cfg_r.inv_time_amp      <= pwdata[30:0];
        REG_INV_TIME_EXC:  cfg_r.inv_time_exciter  <= pwdata[30:0];
        REG_INV_TIME_FB:   cfg_r.inv_time_feedback <= pwdata[30:0];
        REG_SAT_OFFSET:    cfg_r.sat_offset        <= pwdata;
        REG_SAT_SCALE:     cfg_r.sat_scale         <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_AMP:      prdata = cfg_r.gain_amp;
      REG_GAIN_EXCITER:  prdata = cfg_r.gain_exciter;
      REG_GAIN_FEEDBACK: prdata = cfg_r.gain_feedback;
      REG_INV_TIME_AMP:  prdata = {1'b0, cfg_r.inv_time_amp};
      REG_INV_TIME_EXC:  prdata = {1'b0, cfg_r.inv_time_exciter};
      REG_INV_TIME_FB:   prdata = {1'b0, cfg_r.inv_time_feedback};
      REG_SAT_OFFSET:    prdata = cfg_r.sat_offset;
      REG_SAT_SCALE:     prdata = {1'b0, cfg_r.sat_scale};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/exc1d_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exc1d_pipe
// Six-stage derivative datapath. Saturating fixed-point arithmetic in each
// stage, valid bits travel with the data.
// ----------------------------------------------------------------------------
module exc1d_pipe #(
  parameter int INV_TIME_SENSE = 0,
  parameter int FRAC_BITS      = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  exc1d_pkg::in_beat_t  in_beat,
  input  exc1d_pkg::cfg_t      cfg,
  output logic                 out_vld,
  output exc1d_pkg::out_beat_t out_beat
);
  import exc1d_pkg::*;

  localparam logic signed [31:0] InvSense = 32'(INV_TIME_SENSE);
  localparam int                 Stages   = 6;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == {33{v[63]}}) r = v[31:0];
    else if (v[63])              r = 32'sh8000_0000;
    else                         r = 32'sh7fff_ffff;
    return r;
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat64(64'(s));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat64(64'(s));
  endfunction

  function automatic logic signed [31:0] uq(input logic [30:0] v);
    return $signed({1'b0, v});
  endfunction

  logic [Stages-1:0] vld_r;

  // stage 1
  logic signed [31:0] m1_nxt, ke1_nxt, d1_nxt, dvsd1_nxt, t1_nxt, aux;
  logic signed [31:0] m1_r, ke1_r, d1_r, dvsd1_r, t1_r, vr1_r, vf1_r;
  logic               gt1_r;
  logic [1:0]         lim1_r;
  // stage 2
  logic signed [31:0] m2_nxt, a2_nxt, dvs2_nxt, t2_nxt;
  logic signed [31:0] m2_r, a2_r, d2_r, dvs2_r, t2_r, vr2_r, vf2_r;
  logic               gt2_r;
  logic [1:0]         lim2_r;
  // stage 3
  logic signed [31:0] m3, x3_nxt, kav3_nxt;
  logic signed [31:0] x3_r, kav3_r, dvs3_r, vf3_r;
  logic [1:0]         lim3_r;
  // stage 4
  logic signed [31:0] de4_nxt, dvr4_raw, dvr4_nxt;
  logic signed [31:0] de4_r, dvr4_r, dvs4_r, vf4_r;
  // stage 5
  logic signed [31:0] fb5_nxt;
  logic signed [31:0] fb5_r, de5_r, dvr5_r, dvs5_r;
  // stage 6
  out_beat_t          out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[Stages-2:0], in_vld};
  end

  always_comb begin
    aux       = in_beat.uel_active ? in_beat.uel_signal : in_beat.oel_signal;
    m1_nxt    = qmul(uq(cfg.sat_scale), in_beat.field_volt);
    ke1_nxt   = qmul(in_beat.field_volt, cfg.gain_exciter);
    d1_nxt    = qsub(in_beat.field_volt, cfg.sat_offset);
    dvsd1_nxt = qsub(in_beat.gen_volt, in_beat.sensed_volt);
    t1_nxt    = qadd(qsub(in_beat.ref_volt, in_beat.sensed_volt), aux);
  end

  always_ff @(posedge clk) begin
    m1_r    <= m1_nxt;
    ke1_r   <= ke1_nxt;
    d1_r    <= d1_nxt;
    gt1_r   <= in_beat.field_volt > cfg.sat_offset;
    dvsd1_r <= dvsd1_nxt;
    t1_r    <= t1_nxt;
    vr1_r   <= in_beat.reg_out;
    vf1_r   <= in_beat.fb_state;
    lim1_r  <= in_beat.limit_state;
  end

  always_comb begin
    m2_nxt   = qmul(m1_r, d1_r);
    a2_nxt   = qsub(vr1_r, ke1_r);
    dvs2_nxt = qmul(InvSense, dvsd1_r);
    t2_nxt   = qsub(t1_r, vf1_r);
  end

  always_ff @(posedge clk) begin
    m2_r   <= m2_nxt;
    a2_r   <= a2_nxt;
    d2_r   <= d1_r;
    gt2_r  <= gt1_r;
    dvs2_r <= dvs2_nxt;
    t2_r   <= t2_nxt;
    vr2_r  <= vr1_r;
    vf2_r  <= vf1_r;
    lim2_r <= lim1_r;
  end

  // drop the saturation term at or below the offset
  always_comb begin
    m3       = gt2_r ? qmul(m2_r, d2_r) : 32'sd0;
    x3_nxt   = qsub(a2_r, m3);
    kav3_nxt = qsub(qmul(cfg.gain_amp, t2_r), vr2_r);
  end

  always_ff @(posedge clk) begin
    x3_r   <= x3_nxt;
    kav3_r <= kav3_nxt;
    dvs3_r <= dvs2_r;
    vf3_r  <= vf2_r;
    lim3_r <= lim2_r;
  end

  // hold the regulator at its limit
  always_comb begin
    de4_nxt  = qmul(uq(cfg.inv_time_exciter), x3_r);
    dvr4_raw = qmul(uq(cfg.inv_time_amp), kav3_r);
    dvr4_nxt = dvr4_raw;
    if (lim3_r == LIM_MAX && dvr4_raw > 32'sd0)      dvr4_nxt = 32'sd0;
    else if (lim3_r == LIM_MIN && dvr4_raw < 32'sd0) dvr4_nxt = 32'sd0;
  end

  always_ff @(posedge clk) begin
    de4_r  <= de4_nxt;
    dvr4_r <= dvr4_nxt;
    dvs4_r <= dvs3_r;
    vf4_r  <= vf3_r;
  end

  always_comb fb5_nxt = qsub(qmul(cfg.gain_feedback, de4_r), vf4_r);

  always_ff @(posedge clk) begin
    fb5_r  <= fb5_nxt;
    de5_r  <= de4_r;
    dvr5_r <= dvr4_r;
    dvs5_r <= dvs4_r;
  end

  always_ff @(posedge clk) begin
    out_r.d_field_volt  <= de5_r;
    out_r.d_sensed_volt <= dvs5_r;
    out_r.d_reg_out     <= dvr5_r;
    out_r.d_fb_state    <= qmul(uq(cfg.inv_time_feedback), fb5_r);
  end

  assign out_vld  = vld_r[Stages-1];
  assign out_beat = out_r;

endmodule

>>> rtl/exciter_type1_derivative.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exciter_type1_derivative
// Each accepted beat passes through the pipeline registers of exc1d_pipe and
// leaves with out_strobe. Throughput: one beat per cycle; busy stays low.
// Reset (rst_n low, synchronous): clears all valid bits and loads register
// defaults; the receiver cannot stall, so results leave as they finish.
// ----------------------------------------------------------------------------
module exciter_type1_derivative #(
  parameter int INV_TIME_SENSE = 0,
  parameter int FRAC_BITS      = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             in_field_volt,
  input  logic signed [31:0]             in_sensed_volt,
  input  logic signed [31:0]             in_reg_out,
  input  logic signed [31:0]             in_fb_state,
  input  logic signed [31:0]             in_gen_volt,
  input  logic signed [31:0]             in_ref_volt,
  input  logic signed [31:0]             in_oel_signal,
  input  logic signed [31:0]             in_uel_signal,
  input  logic                           in_uel_active,
  input  logic [1:0]                     in_limit_state,
  output logic                           out_strobe,
  output logic signed [31:0]             out_d_field_volt,
  output logic signed [31:0]             out_d_sensed_volt,
  output logic signed [31:0]             out_d_reg_out,
  output logic signed [31:0]             out_d_fb_state,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [exc1d_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import exc1d_pkg::*;

  cfg_t      cfg;
  in_beat_t  in_beat;
  out_beat_t out_beat;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign in_beat.field_volt  = in_field_volt;
  assign in_beat.sensed_volt = in_sensed_volt;
  assign in_beat.reg_out     = in_reg_out;
  assign in_beat.fb_state    = in_fb_state;
  assign in_beat.gen_volt    = in_gen_volt;
  assign in_beat.ref_volt    = in_ref_volt;
  assign in_beat.oel_signal  = in_oel_signal;
  assign in_beat.uel_signal  = in_uel_signal;
  assign in_beat.uel_active  = in_uel_active;
  assign in_beat.limit_state = in_limit_state;

  exc1d_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  exc1d_pipe #(
    .INV_TIME_SENSE (INV_TIME_SENSE),
    .FRAC_BITS      (FRAC_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_beat  (in_beat),
    .cfg      (cfg),
    .out_vld  (out_strobe),
    .out_beat (out_beat)
  );

  assign out_d_field_volt  = out_beat.d_field_volt;
  assign out_d_sensed_volt = out_beat.d_sensed_volt;
  assign out_d_reg_out     = out_beat.d_reg_out;
  assign out_d_fb_state    = out_beat.d_fb_state;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("accepted beat did not produce a result after six cycles");

  a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(accept, 6) && $past(in_limit_state, 6) == LIM_MAX)
      |-> !(out_d_reg_out > 32'sd0))
    else $error("regulator derivative positive at upper limit");

  a_clamp_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(accept, 6) && $past(in_limit_state, 6) == LIM_MIN)
      |-> !(out_d_reg_out < 32'sd0))
    else $error("regulator derivative negative at lower limit");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 6))
    else $error("result strobe without an accepted beat");

endmodule
